// ===== design/thec_pkg.sv =====
// Shared types for the two-hypothesis evidence combiner.
// Request structs for both channels and the per-source flag group.
// No dependencies.
`timescale 1ns / 1ps

package thec_pkg;

  // Width of every mass field on the ports
  localparam int FIELD_W = 16;

  // One evidence source request
  typedef struct packed {
    logic [FIELD_W-1:0] positive_mass;
    logic [FIELD_W-1:0] negative_mass;
    logic               last_source;
  } in_item_t;

  // One combined result request
  typedef struct packed {
    logic [FIELD_W-1:0] yes_belief;
    logic [FIELD_W-1:0] no_belief;
    logic [FIELD_W-1:0] uncertain_belief;
    logic [FIELD_W-1:0] conflict_belief;
    logic               bad_input;
  } out_item_t;

  // Control flags that travel with a prepared source
  typedef struct packed {
    logic last;
    logic bad;
  } src_flags_t;

endpackage

// ===== design/thec_prep.sv =====
// Source preparation: saturates the raw masses, derives the theta mass and
// flags a source whose masses sum above one. Depends on thec_pkg.
`timescale 1ns / 1ps

module thec_prep #(
  parameter int FRAC_BITS = 15
) (
  input  thec_pkg::in_item_t         raw,
  output logic [FRAC_BITS:0]         src_yes,
  output logic [FRAC_BITS:0]         src_no,
  output logic [FRAC_BITS:0]         src_theta,
  output thec_pkg::src_flags_t       src_flags
);

  localparam int MW = FRAC_BITS + 1;
  localparam int XW = ((MW > thec_pkg::FIELD_W) ? MW : thec_pkg::FIELD_W) + 1;
  localparam logic [XW-1:0] ONE_X = XW'(1) << FRAC_BITS;

  logic [XW-1:0] p_x;
  logic [XW-1:0] n_x;
  logic [XW-1:0] sum_x;
  logic          bad;

  // widen so the sum and the compare against one cannot wrap
  assign p_x   = XW'(raw.positive_mass);
  assign n_x   = XW'(raw.negative_mass);
  assign sum_x = p_x + n_x;
  assign bad   = (sum_x > ONE_X);

  // saturate each mass at one; theta clamps to zero on a bad source
  assign src_yes   = (p_x > ONE_X) ? MW'(ONE_X) : MW'(p_x);
  assign src_no    = (n_x > ONE_X) ? MW'(ONE_X) : MW'(n_x);
  assign src_theta = bad ? '0 : MW'(ONE_X - sum_x);

  assign src_flags.last = raw.last_source;
  assign src_flags.bad  = bad;

endmodule

// ===== design/thec_fold.sv =====
// Running-mass fold: holds the group's yes/no/theta masses and folds one
// prepared source in per cycle, while adv is high, by the unnormalized
// combination rule. Depends on thec_pkg.
`timescale 1ns / 1ps

module thec_fold #(
  parameter int FRAC_BITS = 15
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic [FRAC_BITS:0]   src_yes,
  input  logic [FRAC_BITS:0]   src_no,
  input  logic [FRAC_BITS:0]   src_theta,
  input  thec_pkg::src_flags_t src_flags,
  output logic [FRAC_BITS:0]   new_yes,
  output logic [FRAC_BITS:0]   new_no,
  output logic [FRAC_BITS:0]   new_theta,
  output logic                 new_err
);

  localparam int MW = FRAC_BITS + 1;
  localparam int PW = 2 * MW;
  localparam int SW = MW + 2;
  localparam logic [SW-1:0] ONE_S = SW'(1) << FRAC_BITS;

  logic [MW-1:0] run_yes_r, run_yes_nxt;
  logic [MW-1:0] run_no_r, run_no_nxt;
  logic [MW-1:0] run_theta_r, run_theta_nxt;
  logic          first_pending_r, first_pending_nxt;
  logic          error_seen_r, error_seen_nxt;

  logic [SW-1:0] yes_sum;
  logic [SW-1:0] no_sum;
  logic [SW-1:0] theta_sum;

  // truncated Q product, result extended to the sum width
  function automatic logic [SW-1:0] qmul(input logic [MW-1:0] a, input logic [MW-1:0] b);
    logic [PW-1:0] prod;
    prod = PW'(a) * PW'(b);
    return SW'(prod >> FRAC_BITS);
  endfunction

  function automatic logic [MW-1:0] sat_one(input logic [SW-1:0] v);
    return (v > ONE_S) ? MW'(ONE_S) : MW'(v);
  endfunction

  // combination products, all independent of each other
  always_comb begin
    yes_sum   = qmul(run_yes_r, src_yes) + qmul(run_yes_r, src_theta)
              + qmul(run_theta_r, src_yes);
    no_sum    = qmul(run_no_r, src_no) + qmul(run_no_r, src_theta)
              + qmul(run_theta_r, src_no);
    theta_sum = qmul(run_theta_r, src_theta);
  end

  // first source of a group loads, later ones fold
  always_comb begin
    if (first_pending_r) begin
      new_yes   = src_yes;
      new_no    = src_no;
      new_theta = src_theta;
      new_err   = src_flags.bad;
    end else begin
      new_yes   = sat_one(yes_sum);
      new_no    = sat_one(no_sum);
      new_theta = sat_one(theta_sum);
      new_err   = error_seen_r | src_flags.bad;
    end
  end

  // state update on each advancing source
  always_comb begin
    run_yes_nxt       = run_yes_r;
    run_no_nxt        = run_no_r;
    run_theta_nxt     = run_theta_r;
    first_pending_nxt = first_pending_r;
    error_seen_nxt    = error_seen_r;
    if (adv) begin
      run_yes_nxt       = new_yes;
      run_no_nxt        = new_no;
      run_theta_nxt     = new_theta;
      first_pending_nxt = src_flags.last;
      error_seen_nxt    = src_flags.last ? 1'b0 : new_err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_yes_r       <= '0;
      run_no_r        <= '0;
      run_theta_r     <= '0;
      first_pending_r <= 1'b1;
      error_seen_r    <= 1'b0;
    end else begin
      run_yes_r       <= run_yes_nxt;
      run_no_r        <= run_no_nxt;
      run_theta_r     <= run_theta_nxt;
      first_pending_r <= first_pending_nxt;
      error_seen_r    <= error_seen_nxt;
    end
  end

endmodule

// ===== design/two_hypothesis_evidence_combiner.sv =====
// Two-hypothesis evidence combiner, top level: input register, fold stage
// and result register. Depends on thec_pkg, thec_prep and thec_fold.
//
// Usage:
//   Each request on the in_ channel carries one evidence source's yes and
//   no masses in unsigned Q1.FRAC_BITS plus a last_source mark. Sources of
//   a group are folded into running yes/no/theta masses; the request marked
//   last produces one result request on the out_ channel with the combined
//   yes, no and theta masses, the empty-set (conflict) mass and a flag for
//   any source of the group whose masses summed above one.
//   Throughput: one source per cycle while no last source waits on a stalled
//   result; the fold of the running masses is combinational (seven parallel
//   multiplies feeding three saturating sums). A last source passes the input
//   register and fold stage and is loaded into the result register for out_.
//   Sources without the last mark produce no result.
//   Stall: while out_stall holds a result, sources keep flowing until a
//   last-marked source reaches the fold stage; it then waits there and
//   in_stall rises until the result register frees up.
//   Reset (rst_n low, synchronous): both channels go empty and the next
//   source starts a new group.
`timescale 1ns / 1ps

module two_hypothesis_evidence_combiner #(
  parameter int FRAC_BITS = 15
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  thec_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output thec_pkg::out_item_t out_data
);

  localparam int MW = FRAC_BITS + 1;
  localparam int OW = (MW > thec_pkg::FIELD_W) ? MW : thec_pkg::FIELD_W;
  localparam int SW = MW + 2;
  localparam logic [SW-1:0] ONE_S = SW'(1) << FRAC_BITS;

  // prepared source, combinational from the port
  logic [MW-1:0]        prep_yes, prep_no, prep_theta;
  thec_pkg::src_flags_t prep_flags;

  // input register
  logic                 s1_valid_r, s1_valid_nxt;
  logic [MW-1:0]        s1_yes_r, s1_no_r, s1_theta_r;
  thec_pkg::src_flags_t s1_flags_r;

  // fold results
  logic [MW-1:0]        fold_yes, fold_no, fold_theta;
  logic                 fold_err;

  // result register
  logic                 out_valid_r, out_valid_nxt;
  logic [MW-1:0]        out_yes_r, out_no_r, out_theta_r;
  logic                 out_bad_r;

  logic                 out_free;
  logic                 s1_adv;
  logic                 s1_load;
  logic                 out_load;
  logic [SW-1:0]        sum3;
  logic [MW-1:0]        conflict;
  logic [OW-1:0]        yes_w, no_w, theta_w, conflict_w;

  thec_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .raw       (in_data),
    .src_yes   (prep_yes),
    .src_no    (prep_no),
    .src_theta (prep_theta),
    .src_flags (prep_flags)
  );

  // handshake: a last source can only leave the fold stage into a free slot
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && (!s1_flags_r.last || out_free);
  assign out_load = s1_adv && s1_flags_r.last;
  assign in_stall = s1_valid_r && !s1_adv;
  assign s1_load  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_load) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_yes_r   <= prep_yes;
      s1_no_r    <= prep_no;
      s1_theta_r <= prep_theta;
      s1_flags_r <= prep_flags;
    end
    if (out_load) begin
      out_yes_r   <= fold_yes;
      out_no_r    <= fold_no;
      out_theta_r <= fold_theta;
      out_bad_r   <= fold_err;
    end
  end

  thec_fold #(.FRAC_BITS(FRAC_BITS)) u_fold (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (s1_adv),
    .src_yes   (s1_yes_r),
    .src_no    (s1_no_r),
    .src_theta (s1_theta_r),
    .src_flags (s1_flags_r),
    .new_yes   (fold_yes),
    .new_no    (fold_no),
    .new_theta (fold_theta),
    .new_err   (fold_err)
  );

  // conflict mass from the held result, clamped at zero
  assign sum3     = SW'(out_yes_r) + SW'(out_no_r) + SW'(out_theta_r);
  assign conflict = (sum3 >= ONE_S) ? '0 : MW'(ONE_S - sum3);

  // fit to the 16-bit port fields
  assign yes_w      = OW'(out_yes_r);
  assign no_w       = OW'(out_no_r);
  assign theta_w    = OW'(out_theta_r);
  assign conflict_w = OW'(conflict);

  always_comb begin
    out_data.yes_belief       = yes_w[thec_pkg::FIELD_W-1:0];
    out_data.no_belief        = no_w[thec_pkg::FIELD_W-1:0];
    out_data.uncertain_belief = theta_w[thec_pkg::FIELD_W-1:0];
    out_data.conflict_belief  = conflict_w[thec_pkg::FIELD_W-1:0];
    out_data.bad_input        = out_bad_r;
  end

  assign out_valid = out_valid_r;

endmodule

// ===== design/thec_checker.sv =====
// Port-level checks for the evidence combiner, bound to the top level.
// Depends on thec_pkg.
`timescale 1ns / 1ps

module thec_checker #(
  parameter int FRAC_BITS = 15
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input thec_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input thec_pkg::out_item_t out_data
);

  localparam logic [17:0] ONE_C = 18'(1) << ((FRAC_BITS > 15) ? 0 : FRAC_BITS);
  localparam logic        NARROW = (FRAC_BITS <= 15);

  logic [17:0] mass_total;

  assign mass_total = 18'(out_data.yes_belief) + 18'(out_data.no_belief)
                    + 18'(out_data.uncertain_belief) + 18'(out_data.conflict_belief);

  // a stalled result request holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // input backpressure only comes from a full, stalled result slot
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with result slot free");

  // nothing offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result offered after reset");

  // the yes, no and uncertain masses saturate at one
  a_mass_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && NARROW |-> (18'(out_data.yes_belief) <= ONE_C)
      && (18'(out_data.no_belief) <= ONE_C)
      && (18'(out_data.uncertain_belief) <= ONE_C))
    else $error("mass above one");

  // nonzero conflict makes the four masses add up to exactly one
  a_conflict_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && NARROW && (out_data.conflict_belief != '0) |-> mass_total == ONE_C)
    else $error("conflict does not close the mass sum");

  // request fields are not otherwise checked here
  logic unused_in;
  assign unused_in = in_valid ^ (^in_data);

endmodule

bind two_hypothesis_evidence_combiner thec_checker #(.FRAC_BITS(FRAC_BITS)) u_thec_checker (.*);
